// ----- rtl/core/aspf_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package aspf_pkg;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_LOAD  = 2'd1,
    OP_EMIT  = 2'd2,
    OP_NONE  = 2'd3
  } aspf_op_t;

  typedef enum logic [1:0] {
    LIST_ALL   = 2'd0,
    LIST_FIRST = 2'd1,
    LIST_PAIR  = 2'd2,
    LIST_ANY   = 2'd3
  } aspf_list_t;

  typedef enum logic [1:0] {
    REG_FIRST_OCTET_MATCH = 2'd0,
    REG_PAIR_FIRST_OCTET  = 2'd1,
    REG_PAIR_SECOND_OCTET = 2'd2,
    REG_ANY_OCTET_MATCH   = 2'd3
  } aspf_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INSERT,
    ST_INSERT_HEAD,
    ST_EMIT,
    ST_FLUSH
  } aspf_state_t;

  localparam int unsigned ADDR_W  = 32;
  localparam int unsigned OCTET_W = 8;

  localparam logic [OCTET_W-1:0] FIRST_OCTET_RST = 8'd1;
  localparam logic [OCTET_W-1:0] PAIR_FIRST_RST  = 8'd46;
  localparam logic [OCTET_W-1:0] PAIR_SECOND_RST = 8'd70;
  localparam logic [OCTET_W-1:0] ANY_OCTET_RST   = 8'd46;

  typedef struct packed {
    logic [OCTET_W-1:0] first_octet_match;
    logic [OCTET_W-1:0] pair_first_octet;
    logic [OCTET_W-1:0] pair_second_octet;
    logic [OCTET_W-1:0] any_octet_match;
  } aspf_cfg_t;

  // list membership of one stored address
  function automatic logic aspf_selected(input logic [ADDR_W-1:0] a,
                                         input logic [1:0] sel,
                                         input aspf_cfg_t cfg);
    logic [OCTET_W-1:0] o0;
    logic [OCTET_W-1:0] o1;
    logic [OCTET_W-1:0] o2;
    logic [OCTET_W-1:0] o3;
    logic               res;
    o0 = a[31:24];
    o1 = a[23:16];
    o2 = a[15:8];
    o3 = a[7:0];
    case (aspf_list_t'(sel))
      LIST_ALL:   res = 1'b1;
      LIST_FIRST: res = (o0 == cfg.first_octet_match);
      LIST_PAIR:  res = (o0 == cfg.pair_first_octet) && (o1 == cfg.pair_second_octet);
      LIST_ANY:   res = (o0 == cfg.any_octet_match) || (o1 == cfg.any_octet_match) ||
                        (o2 == cfg.any_octet_match) || (o3 == cfg.any_octet_match);
      default:    res = 1'b0;
    endcase
    return res;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/aspf_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none

module aspf_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    // read register holds while re is low
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/address_sort_and_prefix_filter_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Sorted IPv4 address store with octet-match list output. Addresses (first
// octet in bits 31:24) are kept in one single-port-write, registered-read RAM
// in descending unsigned order; duplicates are kept. A load request into a
// non-empty store walks it from its smallest entry upward, moving each smaller
// entry one slot down per cycle, and the input stays busy until the new
// address is written; a load into an empty store writes the head in its
// accept cycle, and a load into a full store is dropped in its accept cycle
// and sets the sticky overflow flag. A clear request empties the store and
// clears that flag. An emit request reads one RAM entry per cycle while the
// filter path is not stalled and keeps the input busy until its final result
// is in the output register; each result is held back one match so that last
// can be flagged, and an empty list gives one result with empty_res set and
// address zero. The read-to-filter path stalls only when a new match has to
// push the held one out while the output register is still full. Requests
// are taken one at a time (in_ready is high only when idle), but the output
// register decouples the sides: the next request is taken while the final
// result of an emit still waits. Configuration registers are written through
// cfg_we/cfg_index/cfg_wdata and must only change while the unit is idle.
module address_sort_and_prefix_filter_unit #(
  parameter int unsigned CAPACITY = 64
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // configuration
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [7:0]  cfg_wdata,
  // request channel
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  op,
  input  wire logic [31:0] address,
  input  wire logic [1:0]  list_select,
  // result channel
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      out_address,
  output logic [1:0]       out_list,
  output logic             last,
  output logic             empty_res,
  output logic             overflow
);

  import aspf_pkg::*;

  localparam int unsigned IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

  aspf_state_t state, state_next;
  aspf_cfg_t   cfg;

  logic [CW-1:0]     count;
  logic              dropped;
  logic [ADDR_W-1:0] ins_addr;
  logic [IW-1:0]     idx;       // entry being compared during insert
  logic [CW-1:0]     rd_idx;    // next entry to read during emit
  logic              rd_vld;    // ram read register holds an entry to filter
  logic [1:0]        sel_reg;
  logic              pend_vld;  // one match held back for last detection
  logic [ADDR_W-1:0] pend_addr;

  // ram port
  logic              ram_we;
  logic [IW-1:0]     ram_waddr;
  logic [ADDR_W-1:0] ram_wdata;
  logic              ram_re;
  logic [IW-1:0]     ram_raddr;
  logic [ADDR_W-1:0] ram_rdata;

  logic in_fire;
  logic out_free;
  logic hit;
  logic stall;
  logic push_mid;   // held match goes out, not last
  logic push_end;   // final result of the emit
  logic shift_down; // stored entry is smaller than the one being inserted

  aspf_ram #(
    .WIDTH(ADDR_W),
    .DEPTH(CAPACITY)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign in_ready   = (state == ST_IDLE);
  assign in_fire    = in_valid && in_ready;
  assign out_free   = !out_valid || out_ready;
  assign hit        = aspf_selected(ram_rdata, sel_reg, cfg);
  assign stall      = (state == ST_EMIT) && rd_vld && hit && pend_vld && !out_free;
  assign push_mid   = (state == ST_EMIT) && rd_vld && hit && pend_vld && out_free;
  assign push_end   = (state == ST_FLUSH) && out_free;
  assign shift_down = (ram_rdata < ins_addr);

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.first_octet_match <= FIRST_OCTET_RST;
      cfg.pair_first_octet  <= PAIR_FIRST_RST;
      cfg.pair_second_octet <= PAIR_SECOND_RST;
      cfg.any_octet_match   <= ANY_OCTET_RST;
    end else if (cfg_we) begin
      case (aspf_reg_t'(cfg_index))
        REG_FIRST_OCTET_MATCH: cfg.first_octet_match <= cfg_wdata;
        REG_PAIR_FIRST_OCTET:  cfg.pair_first_octet  <= cfg_wdata;
        REG_PAIR_SECOND_OCTET: cfg.pair_second_octet <= cfg_wdata;
        REG_ANY_OCTET_MATCH:   cfg.any_octet_match   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // next state and ram access
  always_comb begin
    state_next = state;
    ram_we     = 1'b0;
    ram_waddr  = '0;
    ram_wdata  = ins_addr;
    ram_re     = 1'b0;
    ram_raddr  = '0;
    case (state)
      ST_IDLE: begin
        if (in_fire) begin
          case (aspf_op_t'(op))
            OP_LOAD: begin
              if (count == '0) begin
                // empty store: write straight to the head
                ram_we    = 1'b1;
                ram_wdata = address;
              end else if (count != CAP_C) begin
                // start at the smallest entry
                ram_re     = 1'b1;
                ram_raddr  = IW'(count - CW'(1));
                state_next = ST_INSERT;
              end
            end
            OP_EMIT: state_next = ST_EMIT;
            default: ;
          endcase
        end
      end
      ST_INSERT: begin
        ram_we    = 1'b1;
        ram_waddr = idx + IW'(1);
        if (shift_down) begin
          ram_wdata = ram_rdata;
          if (idx == '0) begin
            state_next = ST_INSERT_HEAD;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = idx - IW'(1);
          end
        end else begin
          ram_wdata  = ins_addr;
          state_next = ST_IDLE;
        end
      end
      ST_INSERT_HEAD: begin
        ram_we     = 1'b1;
        ram_waddr  = '0;
        ram_wdata  = ins_addr;
        state_next = ST_IDLE;
      end
      ST_EMIT: begin
        ram_re    = (rd_idx != count) && !stall;
        ram_raddr = rd_idx[IW-1:0];
        if (rd_idx == count && !rd_vld) begin
          state_next = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // store bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      dropped <= 1'b0;
    end else begin
      if (in_fire && aspf_op_t'(op) == OP_CLEAR) begin
        count   <= '0;
        dropped <= 1'b0;
      end else if (in_fire && aspf_op_t'(op) == OP_LOAD && count == CAP_C) begin
        dropped <= 1'b1;
      end else if (in_fire && aspf_op_t'(op) == OP_LOAD && count == '0) begin
        count <= count + CW'(1);
      end else if (state == ST_INSERT && !shift_down) begin
        count <= count + CW'(1);
      end else if (state == ST_INSERT_HEAD) begin
        count <= count + CW'(1);
      end
    end
  end

  // insert walk
  always_ff @(posedge clk) begin
    if (in_fire) begin
      ins_addr <= address;
      idx      <= IW'(count - CW'(1));
      sel_reg  <= list_select;
    end else if (state == ST_INSERT && shift_down && idx != '0) begin
      idx <= idx - IW'(1);
    end
  end

  // emit walk and held-back match
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld   <= 1'b0;
      pend_vld <= 1'b0;
      rd_idx   <= '0;
    end else begin
      if (in_fire) begin
        rd_idx   <= '0;
        rd_vld   <= 1'b0;
        pend_vld <= 1'b0;
      end else if (state == ST_EMIT) begin
        if (!stall) begin
          rd_vld <= ram_re;
          if (ram_re) begin
            rd_idx <= rd_idx + CW'(1);
          end
          if (rd_vld && hit) begin
            pend_vld  <= 1'b1;
            pend_addr <= ram_rdata;
          end
        end
      end else if (push_end) begin
        pend_vld <= 1'b0;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (push_mid || push_end) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push_mid || push_end) begin
      out_address <= pend_vld ? pend_addr : '0;
      out_list    <= sel_reg;
      last        <= push_end;
      empty_res   <= push_end && !pend_vld;
      overflow    <= dropped;
    end
  end

  // store never holds more than its capacity
  assert property (@(posedge clk) disable iff (rst) count <= CAP_C)
    else $error("entry count above capacity");

  // a stall only happens while a result is waiting in the output register
  assert property (@(posedge clk) disable iff (rst) stall |-> out_valid)
    else $error("emit stalled with free output register");

  // no read or held match survives back to idle
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> (!rd_vld && !pend_vld))
    else $error("emit state left behind at idle");

  // a load into a full store leaves the count alone and raises overflow
  assert property (@(posedge clk) disable iff (rst)
    (in_fire && aspf_op_t'(op) == OP_LOAD && count == CAP_C) |=> (dropped && $stable(count)))
    else $error("dropped load changed the store");

endmodule

`default_nettype wire
